@@ design/vrlp_pkg.sv @@
// vrlp_pkg: shared constants for the vertex rotate/light/project pipeline.
// No dependencies.
`timescale 1ns / 1ps
package vrlp_pkg;
  localparam int unsigned RegIdxW = 3;
  // fraction bits of normals, trig values and the light vector
  localparam int unsigned NormFrac = 14;

  localparam logic [RegIdxW-1:0] RegCos    = 3'd0;
  localparam logic [RegIdxW-1:0] RegSin    = 3'd1;
  localparam logic [RegIdxW-1:0] RegPivot  = 3'd2;
  localparam logic [RegIdxW-1:0] RegLightX = 3'd3;
  localparam logic [RegIdxW-1:0] RegLightY = 3'd4;
  localparam logic [RegIdxW-1:0] RegLightZ = 3'd5;
  localparam logic [RegIdxW-1:0] RegCentX  = 3'd6;
  localparam logic [RegIdxW-1:0] RegCentY  = 3'd7;

  typedef struct packed {
    logic signed [15:0] cos_angle;
    logic signed [15:0] sin_angle;
    logic signed [18:0] pivot_z;
    logic signed [15:0] light_x;
    logic signed [15:0] light_y;
    logic signed [15:0] light_z;
    logic [11:0]        center_x;
    logic [11:0]        center_y;
  } cfg_t;
endpackage

@@ design/vrlp_div.sv @@
// vrlp_div: pipelined signed divider, truncating toward zero, one quotient bit a stage.
// Depends on nothing; stall freezes every stage.
`timescale 1ns / 1ps
module vrlp_div #(
  parameter int unsigned NW = 31,
  parameter int unsigned DW = 19
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic signed [NW-1:0] num,
  input  logic signed [DW-1:0] den,
  output logic signed [NW-1:0] quo
);
  // magnitude long division, one bit per stage
  logic [NW-1:0] rem [NW+1];
  logic [NW-1:0] q   [NW+1];
  logic [DW-1:0] d   [NW+1];
  logic          neg [NW+1];

  assign rem[0] = num[NW-1] ? NW'(-num) : NW'(num);
  assign d[0]   = den[DW-1] ? DW'(-den) : DW'(den);
  assign neg[0] = num[NW-1] ^ den[DW-1];
  assign q[0]   = '0;

  for (genvar i = 0; i < NW; i++) begin : g_st
    localparam int unsigned B = NW - 1 - i;
    logic [NW+DW-1:0] trial;
    logic             fit;
    assign trial = {{DW{1'b0}}, rem[i]} >> B;
    assign fit   = trial >= {{NW{1'b0}}, d[i]};
    always_ff @(posedge clk) begin
      if (en) begin
        rem[i+1] <= fit ? rem[i] - NW'({{NW{1'b0}}, d[i]} << B) : rem[i];
        q[i+1]   <= q[i] | (NW'(fit) << B);
        d[i+1]   <= d[i];
        neg[i+1] <= neg[i];
      end
    end
  end

  assign quo = neg[NW] ? -$signed(q[NW]) : $signed(q[NW]);
endmodule

@@ design/vrlp_rot.sv @@
// vrlp_rot: one plane rotation stage pair (multiply, then sum and round).
// Depends on vrlp_pkg via NormFrac from the top level.
`timescale 1ns / 1ps
module vrlp_rot #(
  parameter int unsigned W = 22,
  parameter int unsigned F = 14
) (
  input  logic                clk,
  input  logic                en,
  input  logic signed [W-1:0] a,
  input  logic signed [W-1:0] b,
  input  logic signed [15:0]  c,
  input  logic signed [15:0]  s,
  output logic signed [W:0]   ra,
  output logic signed [W:0]   rb
);
  localparam int unsigned PW = W + 17;
  logic signed [PW-1:0] ac, bs, as_, bc;
  always_ff @(posedge clk) begin
    if (en) begin
      ac  <= PW'(a) * PW'(c);
      bs  <= PW'(b) * PW'(s);
      as_ <= PW'(a) * PW'(s);
      bc  <= PW'(b) * PW'(c);
    end
  end
  logic signed [PW:0] sa, sb;
  localparam logic signed [PW:0] Half = (PW+1)'(1) <<< (F - 1);
  assign sa = (PW+1)'(ac) - (PW+1)'(bs) + Half;
  assign sb = (PW+1)'(as_) + (PW+1)'(bc) + Half;
  always_ff @(posedge clk) begin
    if (en) begin
      ra <= (W+1)'(sa >>> F);
      rb <= (W+1)'(sb >>> F);
    end
  end
endmodule

@@ design/vertex_rotate_light_project.sv @@
// vertex_rotate_light_project: top level of the vertex geometry pipeline.
// Depends on vrlp_pkg, vrlp_rot and vrlp_div.
`timescale 1ns / 1ps
// Usage:
//  - Input channel: in_valid/in_stall carry one vertex request (position Q11.8,
//    normal Q1.14, apply_rotation). Accepted when in_valid & !in_stall.
//  - Output channel: out_valid/out_stall carry one result per request:
//    rotated position and normal, intensity, projected screen x/y, depth_zero.
//  - Config: cfg_we writes register cfg_idx with cfg_data; write only when idle.
//  - Pipeline: 4 rotation stages (two multiply/round pairs), a saturate and
//    select stage, a stage of light products and projection numerators (the
//    brightness sum sits behind it), a divider of 32 one-bit stages and a final
//    offset/saturate stage that drives out_valid.
//  - Throughput: one request per clock; the whole pipe advances as one unit,
//    gated by the output register being free or taken.
//  - Stall: when out_stall holds a valid result, every stage freezes and
//    in_stall rises; nothing is lost or repeated.
//  - Reset (rst, synchronous): clears stage valid bits and loads register
//    defaults (cos 1.0, sin 0, pivot 0, light +z, centres 500).
module vertex_rotate_light_project #(
  parameter int unsigned FOCAL_LENGTH = 500
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_idx,
  input  logic [18:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic signed [18:0] pos_x,
  input  logic signed [18:0] pos_y,
  input  logic signed [18:0] pos_z,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic               apply_rotation,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [18:0] new_x,
  output logic signed [18:0] new_y,
  output logic signed [18:0] new_z,
  output logic signed [15:0] new_normal_x,
  output logic signed [15:0] new_normal_y,
  output logic signed [15:0] new_normal_z,
  output logic signed [15:0] screen_x,
  output logic signed [15:0] screen_y,
  output logic [7:0]         intensity,
  output logic               depth_zero
);
  localparam int unsigned F   = vrlp_pkg::NormFrac;
  localparam int unsigned NW  = 32;   // 19b x 12b focal, signed
  localparam int unsigned DIVL = NW;  // divider stages
  localparam int unsigned LAT = 4 + 2 + DIVL + 1;

  vrlp_pkg::cfg_t cfg;
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cos_angle <= 16'sd16384;
      cfg.sin_angle <= '0;
      cfg.pivot_z   <= '0;
      cfg.light_x   <= '0;
      cfg.light_y   <= '0;
      cfg.light_z   <= 16'sd16384;
      cfg.center_x  <= 12'd500;
      cfg.center_y  <= 12'd500;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        vrlp_pkg::RegCos:    cfg.cos_angle <= cfg_data[15:0];
        vrlp_pkg::RegSin:    cfg.sin_angle <= cfg_data[15:0];
        vrlp_pkg::RegPivot:  cfg.pivot_z   <= cfg_data;
        vrlp_pkg::RegLightX: cfg.light_x   <= cfg_data[15:0];
        vrlp_pkg::RegLightY: cfg.light_y   <= cfg_data[15:0];
        vrlp_pkg::RegLightZ: cfg.light_z   <= cfg_data[15:0];
        vrlp_pkg::RegCentX:  cfg.center_x  <= cfg_data[11:0];
        vrlp_pkg::RegCentY:  cfg.center_y  <= cfg_data[11:0];
        default: ;
      endcase
    end
  end

  // whole pipe moves when the output is free or being taken
  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  logic [LAT-1:0] vld;
  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else if (en) vld <= {vld[LAT-2:0], in_valid};
  end
  assign out_valid = vld[LAT-1];

  // input side: apply flag and raw values delayed alongside rotation (4 stages)
  logic signed [19:0] zr_in;
  assign zr_in = 20'(pos_z) - 20'(cfg.pivot_z);

  // z rotation: (x,y) position, (nx,ny) normal; each turn can double the range
  logic signed [20:0] px1, py1;
  logic signed [17:0] nx1, ny1;
  vrlp_rot #(.W(20), .F(F)) u_pz (.clk, .en, .a(20'(pos_x)), .b(20'(pos_y)),
    .c(cfg.cos_angle), .s(cfg.sin_angle), .ra(px1), .rb(py1));
  vrlp_rot #(.W(17), .F(F)) u_nz (.clk, .en, .a(17'(normal_x)), .b(17'(normal_y)),
    .c(cfg.cos_angle), .s(cfg.sin_angle), .ra(nx1), .rb(ny1));

  logic signed [19:0] zr_d [2];
  logic signed [15:0] nz_d [2];
  always_ff @(posedge clk) begin
    if (en) begin
      zr_d[0] <= zr_in;    zr_d[1] <= zr_d[0];
      nz_d[0] <= normal_z; nz_d[1] <= nz_d[0];
    end
  end

  // x rotation: (y,z)
  logic signed [22:0] py2, pz2;
  logic signed [19:0] ny2, nz2;
  vrlp_rot #(.W(22), .F(F)) u_px (.clk, .en, .a(22'(py1)), .b(22'(zr_d[1])),
    .c(cfg.cos_angle), .s(cfg.sin_angle), .ra(py2), .rb(pz2));
  vrlp_rot #(.W(19), .F(F)) u_nx (.clk, .en, .a(19'(ny1)), .b(19'(nz_d[1])),
    .c(cfg.cos_angle), .s(cfg.sin_angle), .ra(ny2), .rb(nz2));

  logic signed [20:0] px_d [2];
  logic signed [17:0] nx_d [2];
  logic signed [18:0] rx [4], ry [4], rz [4];
  logic signed [15:0] rnx [4], rny [4], rnz [4];
  logic               rot [4];
  always_ff @(posedge clk) begin
    if (en) begin
      px_d[0] <= px1; px_d[1] <= px_d[0];
      nx_d[0] <= nx1; nx_d[1] <= nx_d[0];
      rx[0] <= pos_x; ry[0] <= pos_y; rz[0] <= pos_z;
      rnx[0] <= normal_x; rny[0] <= normal_y; rnz[0] <= normal_z;
      rot[0] <= apply_rotation;
      for (int i = 1; i < 4; i++) begin
        rx[i] <= rx[i-1]; ry[i] <= ry[i-1]; rz[i] <= rz[i-1];
        rnx[i] <= rnx[i-1]; rny[i] <= rny[i-1]; rnz[i] <= rnz[i-1];
        rot[i] <= rot[i-1];
      end
    end
  end

  // saturate + select, lighting products
  function automatic logic signed [18:0] sat19(input logic signed [22:0] v);
    if (v > 23'sd262143) return 19'sd262143;
    if (v < -23'sd262144) return -19'sd262144;
    return v[18:0];
  endfunction
  function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
    if (v > 20'sd32767) return 16'sd32767;
    if (v < -20'sd32768) return -16'sd32768;
    return v[15:0];
  endfunction

  logic signed [22:0] zfull;
  assign zfull = 23'(pz2) + 23'(cfg.pivot_z);

  logic signed [18:0] sx5, sy5, sz5;
  logic signed [15:0] snx5, sny5, snz5;
  logic signed [31:0] lpx, lpy, lpz;
  always_ff @(posedge clk) begin
    if (en) begin
      sx5  <= rot[3] ? sat19(23'(px_d[1])) : rx[3];
      sy5  <= rot[3] ? sat19(py2) : ry[3];
      sz5  <= rot[3] ? sat19(zfull) : rz[3];
      snx5 <= rot[3] ? sat16(20'(nx_d[1])) : rnx[3];
      sny5 <= rot[3] ? sat16(ny2) : rny[3];
      snz5 <= rot[3] ? sat16(nz2) : rnz[3];
    end
  end
  always_ff @(posedge clk) begin
    if (en) begin
      lpx <= 32'(snx5) * 32'(cfg.light_x);
      lpy <= 32'(sny5) * 32'(cfg.light_y);
      lpz <= 32'(snz5) * 32'(cfg.light_z);
    end
  end

  // numerators; brightness finished in the same stage
  logic signed [NW-1:0] numx, numy;
  logic signed [18:0] x6, y6, z6;
  logic signed [15:0] nx6, ny6, nz6;
  always_ff @(posedge clk) begin
    if (en) begin
      numx <= NW'(sx5) * NW'($signed({1'b0, 12'(FOCAL_LENGTH)}));
      numy <= NW'(sy5) * NW'($signed({1'b0, 12'(FOCAL_LENGTH)}));
      x6 <= sx5; y6 <= sy5; z6 <= sz5;
      nx6 <= snx5; ny6 <= sny5; nz6 <= snz5;
    end
  end
  logic signed [33:0] bri;
  logic [43:0] bsc;
  logic [7:0]  inten6;
  assign bri = 34'(lpz) - 34'(lpx) - 34'(lpy);
  assign bsc = 44'(bri[32:0]) * 44'd255 >> (2 * F);
  assign inten6 = (bri <= 0) ? 8'd0 : ((bsc > 44'd255) ? 8'd255 : bsc[7:0]);

  logic [7:0] inten7;
  always_ff @(posedge clk) if (en) inten7 <= inten6;

  logic signed [NW-1:0] qx, qy;
  vrlp_div #(.NW(NW), .DW(19)) u_dx (.clk, .en, .num(numx), .den(z6), .quo(qx));
  vrlp_div #(.NW(NW), .DW(19)) u_dy (.clk, .en, .num(numy), .den(z6), .quo(qy));

  // side data through the divider
  logic signed [18:0] dx [DIVL], dy [DIVL], dzv [DIVL];
  logic signed [15:0] dnx [DIVL], dny [DIVL], dnz [DIVL];
  logic [7:0] din [DIVL];
  always_ff @(posedge clk) begin
    if (en) begin
      dx[0] <= x6; dy[0] <= y6; dzv[0] <= z6;
      dnx[0] <= nx6; dny[0] <= ny6; dnz[0] <= nz6; din[0] <= inten6;
      for (int i = 1; i < DIVL; i++) begin
        dx[i] <= dx[i-1]; dy[i] <= dy[i-1]; dzv[i] <= dzv[i-1];
        dnx[i] <= dnx[i-1]; dny[i] <= dny[i-1]; dnz[i] <= dnz[i-1];
        din[i] <= din[i-1];
      end
    end
  end

  function automatic logic signed [15:0] satS(input logic signed [NW:0] v);
    if (v > (NW+1)'(32767)) return 16'sd32767;
    if (v < -(NW+1)'(32768)) return -16'sd32768;
    return v[15:0];
  endfunction

  logic zz;
  assign zz = (dzv[DIVL-1] == '0);
  always_ff @(posedge clk) begin
    if (en) begin
      new_x <= dx[DIVL-1]; new_y <= dy[DIVL-1]; new_z <= dzv[DIVL-1];
      new_normal_x <= dnx[DIVL-1]; new_normal_y <= dny[DIVL-1];
      new_normal_z <= dnz[DIVL-1];
      intensity <= din[DIVL-1];
      depth_zero <= zz;
      screen_x <= zz ? 16'($signed({1'b0, cfg.center_x}))
                     : satS((NW+1)'(qx) + (NW+1)'($signed({1'b0, cfg.center_x})));
      screen_y <= zz ? 16'($signed({1'b0, cfg.center_y}))
                     : satS((NW+1)'(qy) + (NW+1)'($signed({1'b0, cfg.center_y})));
    end
  end

  // inten7 is a debug tap of lighting alignment
  a_inten: assert property (@(posedge clk) disable iff (rst)
    en && vld[6] |=> din[0] == inten7) else $error("light side data misaligned");
  a_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(screen_x) && $stable(new_z))
    else $error("result lost under stall");
  a_dz: assert property (@(posedge clk) disable iff (rst)
    out_valid && depth_zero |-> new_z == '0) else $error("depth flag wrong");
  a_ready: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall) else $error("stalled with free output");
endmodule
